// ===== rtl/core/sprite_line_scan_sorted_assert.svh =====
// Assertion macros for the sprite line scan block.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef SPRITE_LINE_SCAN_SORTED_ASSERT_SVH
`define SPRITE_LINE_SCAN_SORTED_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property must hold on every clock edge outside reset
`define SLS_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: check failed");

// Condition must never be seen outside reset
`define SLS_ASSERT_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) (!(cond))) \
    else $error("%m: forbidden condition seen");

`else

`define SLS_ASSERT(name, clk, rstn, prop)
`define SLS_ASSERT_NEVER(name, clk, rstn, cond)

`endif

`endif

// ===== rtl/core/sls_pkg.sv =====
// Shared types and constants for the sprite line scan block.
// No dependencies; imported by every module of the block.
package sls_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CURRENT_LINE = 2'd0,
    CFG_TALL_SPRITES = 2'd1
  } cfg_reg_e;

  // Selection window arithmetic, 9 bits so sums never wrap
  localparam logic [8:0] LINE_OFFSET  = 9'd16;
  localparam logic [8:0] SHORT_HEIGHT = 9'd8;
  localparam logic [8:0] TALL_HEIGHT  = 9'd16;

  // Output field limits
  localparam logic [3:0] COUNT_SAT = 4'hF;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic       first_entry;
    logic       last_entry;
    logic [7:0] sprite_y;
    logic [7:0] sprite_x;
    logic [7:0] sprite_tile;
    logic [7:0] sprite_attrs;
  } sprite_in_t;

  typedef struct packed {
    logic [3:0] slot;
    logic [7:0] out_y;
    logic [7:0] out_x;
    logic [7:0] out_tile;
    logic [7:0] out_attrs;
    logic [3:0] selected_count;
    logic       none_found;
    logic       run_last;
  } sprite_out_t;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] x;
    logic [7:0] tile;
    logic [7:0] attrs;
  } oam_entry_t;

  // Classified entry handed from front to back
  typedef struct packed {
    logic       first;
    logic       last;
    logic       hit;
    oam_entry_t entry;
  } scan_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== rtl/core/sls_front.sv =====
// Front end: configuration registers, input handshake and entry classification.
// Depends on sls_pkg.
module sls_front import sls_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sprite_in_t            in_data_i,
  input  queue_status_t         q_status_i,
  output logic                  push_o,
  output scan_op_t              push_op_o
);

  logic [7:0] line_q;
  logic       tall_q;
  logic [8:0] target;
  logic [8:0] height;
  logic [8:0] y_ext;
  logic [8:0] y_bottom;
  logic       visible;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
      tall_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_CURRENT_LINE: line_q <= cfg_data_i[7:0];
        CFG_TALL_SPRITES: tall_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Window test: x nonzero and y <= line+16 < y+height
  assign target   = {1'b0, line_q} + LINE_OFFSET;
  assign height   = tall_q ? TALL_HEIGHT : SHORT_HEIGHT;
  assign y_ext    = {1'b0, in_data_i.sprite_y};
  assign y_bottom = y_ext + height;
  assign visible  = (in_data_i.sprite_x != 8'd0) && (y_ext <= target) && (y_bottom > target);

  // Handshake: take a transaction whenever the queue has room
  assign in_ready_o = !q_status_i.full;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    push_op_o.first       = in_data_i.first_entry;
    push_op_o.last        = in_data_i.last_entry;
    push_op_o.hit         = visible;
    push_op_o.entry.y     = in_data_i.sprite_y;
    push_op_o.entry.x     = in_data_i.sprite_x;
    push_op_o.entry.tile  = in_data_i.sprite_tile;
    push_op_o.entry.attrs = in_data_i.sprite_attrs;
  end

endmodule

// ===== rtl/core/sls_queue.sv =====
// Short queue of classified entries between front and back.
// Depends on sls_pkg.
module sls_queue import sls_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  scan_op_t      push_op_i,
  input  logic          pop_i,
  output scan_op_t      head_o,
  output queue_status_t status_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

  scan_op_t        mem_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q;
  logic [PW-1:0]   rd_ptr_q;
  logic [FW-1:0]   fill_q;
  logic            do_push;
  logic            do_pop;

  assign status_o.full  = (fill_q == FW'(QUEUE_DEPTH));
  assign status_o.empty = (fill_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill_q <= fill_q + 1'b1;
        2'b01:   fill_q <= fill_q - 1'b1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

// ===== rtl/core/sls_back.sv =====
// Back end: x-sorted insertion into the selected list and run emission.
// Depends on sls_pkg.
module sls_back import sls_pkg::*; #(
  parameter int unsigned MAX_SPRITES = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  scan_op_t      head_i,
  input  queue_status_t q_status_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sprite_out_t   out_data_o
);

  localparam int unsigned CW = $clog2(MAX_SPRITES + 1);
  localparam int unsigned IW = (MAX_SPRITES > 1) ? $clog2(MAX_SPRITES) : 1;

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_EMIT = 2'b10
  } back_state_e;

  back_state_e     state_q;
  back_state_e     state_d;
  logic [CW-1:0]   count_q;
  logic [CW-1:0]   idx_q;
  logic [CW-1:0]   idx_d;
  logic [CW-1:0]   eff_count;
  logic [CW-1:0]   idx_next;
  logic [4:0]      count_ext;
  logic [4:0]      idx_ext;
  oam_entry_t      list_q [MAX_SPRITES];
  oam_entry_t      rd_entry;
  logic [MAX_SPRITES-1:0] gt;
  logic            do_ins;
  logic            out_free;
  logic            emit;
  logic            run_end;
  sprite_out_t     out_q;
  sprite_out_t     out_d;
  logic            out_valid_q;

  // Pop one classified entry while not emitting
  assign pop_o     = (state_q == BK_IDLE) && !q_status_i.empty;
  assign eff_count = head_i.first ? '0 : count_q;
  assign do_ins    = pop_o && head_i.hit && (eff_count < CW'(MAX_SPRITES));

  // Kept entries with larger x move up one place
  for (genvar k = 0; k < MAX_SPRITES; k++) begin : g_cmp
    assign gt[k] = (CW'(k) < eff_count) && (list_q[k].x > head_i.entry.x);
  end

  for (genvar k = 0; k < MAX_SPRITES; k++) begin : g_list
    if (k == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (do_ins && (gt[k] || (CW'(k) == eff_count))) begin
          list_q[k] <= head_i.entry;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk_i) begin
        if (do_ins) begin
          if (gt[k-1]) begin
            list_q[k] <= list_q[k-1];
          end else if (gt[k] || (CW'(k) == eff_count)) begin
            list_q[k] <= head_i.entry;
          end
        end
      end
    end
  end

  // Emission sequencing
  assign out_free  = !out_valid_q || out_ready_i;
  assign emit      = (state_q == BK_EMIT) && out_free;
  assign idx_next  = idx_q + 1'b1;
  assign run_end   = (count_q == '0) || (idx_next == count_q);
  assign rd_entry  = list_q[idx_q[IW-1:0]];
  assign count_ext = 5'(count_q);
  assign idx_ext   = 5'(idx_q);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      BK_IDLE: begin
        if (pop_o && head_i.last) begin
          state_d = BK_EMIT;
          idx_d   = '0;
        end
      end
      BK_EMIT: begin
        if (emit) begin
          idx_d = idx_next;
          if (run_end) begin
            state_d = BK_IDLE;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Result word for the current slot, or the none-found marker
  always_comb begin
    out_d = '0;
    if (count_q == '0) begin
      out_d.none_found = 1'b1;
      out_d.run_last   = 1'b1;
    end else begin
      out_d.slot           = idx_ext[3:0];
      out_d.out_y          = rd_entry.y;
      out_d.out_x          = rd_entry.x;
      out_d.out_tile       = rd_entry.tile;
      out_d.out_attrs      = rd_entry.attrs;
      out_d.selected_count = (count_ext > 5'd15) ? COUNT_SAT : count_ext[3:0];
      out_d.run_last       = (idx_next == count_q);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (pop_o) begin
        count_q <= eff_count + CW'(do_ins);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/sprite_line_scan_sorted.sv =====
// Top level of the sprite line scan: front, queue and back joined together.
// Depends on sls_pkg, sls_front, sls_queue, sls_back and the assertion header.
//
//  channel  direction  handshake               payload
//  cfg      in         cfg_we_i                cfg_idx_i, cfg_data_i
//  in       in         in_valid_i/in_ready_o   in_data_i (sprite_in_t)
//  out      out        out_valid_o/out_ready_i out_data_o (sprite_out_t)
//
// The front classifies a transaction in the cycle it is accepted and writes it
// into a two-entry queue; the back pops one entry per cycle while it is not emitting
// and inserts it into the sorted list in that cycle, so entries flow at one per cycle.
// After a last entry the back emits count results (one when empty), one per cycle
// while the receiver is ready, through the output register; meanwhile the queue
// fills until full. Reset clears control state only; no clearing pass is needed.
`include "sprite_line_scan_sorted_assert.svh"

module sprite_line_scan_sorted import sls_pkg::*; #(
  parameter int unsigned MAX_SPRITES = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sprite_in_t            in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sprite_out_t           out_data_o
);

  queue_status_t q_status;
  logic          push;
  scan_op_t      push_op;
  logic          pop;
  scan_op_t      head;
  logic          none_ok;
  logic          slot_ok;

  sls_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_status_i (q_status),
    .push_o     (push),
    .push_op_o  (push_op)
  );

  sls_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .pop_i     (pop),
    .head_o    (head),
    .status_o  (q_status)
  );

  sls_back #(
    .MAX_SPRITES (MAX_SPRITES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Shape of the none-found result and range of the slot
  assign none_ok = out_data_o.run_last && (out_data_o.slot == '0) &&
                   (out_data_o.selected_count == '0);
  assign slot_ok = (out_data_o.slot <= out_data_o.selected_count);

  // Assertions
  `SLS_ASSERT(a_none_is_single, clk_i, rst_ni, (out_valid_o && out_data_o.none_found) |-> none_ok)
  `SLS_ASSERT(a_slot_in_count, clk_i, rst_ni, (out_valid_o && !out_data_o.none_found) |-> slot_ok)
  `SLS_ASSERT_NEVER(a_ready_when_full, clk_i, rst_ni, q_status.full && in_ready_o)
  `SLS_ASSERT_NEVER(a_pop_when_empty, clk_i, rst_ni, pop && q_status.empty)

endmodule

// ===== tb/sprite_line_scan_sorted_tb.sv =====
// Self-checking testbench for the sprite line scan: directed table then random line scans.
// Depends on sls_pkg and the sprite_line_scan_sorted RTL; nothing else.
module sprite_line_scan_sorted_tb;
  import sls_pkg::*;

  localparam int unsigned CLK_PERIOD     = 8;
  localparam int unsigned MAX_KEPT       = 10;
  localparam int unsigned RANDOM_ITEMS   = 395;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned LONG_HOLD      = 150;
  localparam int unsigned TIMEOUT_CYCLES = 1_000_000;
  localparam int unsigned MAX_REPORTS    = 50;

  // Register indexes that map to nothing; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FREE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FREE_B = 2'd3;

  // One row of the directed table
  typedef struct {
    bit          set_cfg;
    logic [7:0]  line;
    logic        tall;
    sprite_in_t  entry;
    bit          fixed;
    sprite_out_t fixed_res;
  } scan_row_t;

  // Hand-written result attached to a transaction, if any
  typedef struct {
    bit          fixed;
    sprite_out_t res;
  } hand_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  sprite_in_t            in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  sprite_out_t           out_data_o;

  // Shadow of the block: configuration and the x-sorted selection list
  logic [7:0]    line_reg;
  logic          tall_reg;
  oam_entry_t    kept_list [MAX_KEPT];
  logic [4:0]    kept_count;
  sprite_out_t   line_results [$];
  sprite_out_t   results_due [$];
  hand_result_t  hand_results_q [$];

  // Run bookkeeping
  int unsigned fail_count;
  int unsigned entries_seen;
  int unsigned results_seen;
  int unsigned scans_seen;
  int unsigned empty_runs;
  int unsigned full_runs;
  int unsigned cfg_updates;
  logic [7:0]  prev_x;
  bit          tx_calm;
  bit          rx_calm;
  bit          hold_armed;
  bit          hold_busy;

  sprite_line_scan_sorted #(
    .MAX_SPRITES(MAX_KEPT)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic sprite_in_t mk_entry(logic first, logic last, logic [7:0] y,
                                          logic [7:0] x, logic [7:0] tile,
                                          logic [7:0] attrs);
    sprite_in_t e;
    e.first_entry  = first;
    e.last_entry   = last;
    e.sprite_y     = y;
    e.sprite_x     = x;
    e.sprite_tile  = tile;
    e.sprite_attrs = attrs;
    return e;
  endfunction

  function automatic sprite_out_t mk_result(logic [3:0] slot, logic [7:0] y, logic [7:0] x,
                                            logic [7:0] tile, logic [7:0] attrs,
                                            logic [3:0] cnt, logic none, logic fin);
    sprite_out_t r;
    r.slot           = slot;
    r.out_y          = y;
    r.out_x          = x;
    r.out_tile       = tile;
    r.out_attrs      = attrs;
    r.selected_count = cnt;
    r.none_found     = none;
    r.run_last       = fin;
    return r;
  endfunction

  function automatic scan_row_t mk_row(bit set_cfg, logic [7:0] line, logic tall,
                                       sprite_in_t e);
    scan_row_t r;
    r.set_cfg   = set_cfg;
    r.line      = line;
    r.tall      = tall;
    r.entry     = e;
    r.fixed     = 1'b0;
    r.fixed_res = '0;
    return r;
  endfunction

  // Window test, sorted insert, and the run emitted after a last entry
  function automatic void select_and_sort(sprite_in_t it);
    int unsigned target;
    int unsigned height;
    int          pos;
    logic [3:0]  cnt;
    line_results.delete();
    if (it.first_entry) kept_count = '0;
    target = line_reg + LINE_OFFSET;
    height = tall_reg ? TALL_HEIGHT : SHORT_HEIGHT;
    if (it.sprite_x != 8'd0 && it.sprite_y <= target && it.sprite_y + height > target &&
        kept_count < MAX_KEPT) begin
      pos = 0;
      // equal x goes behind the ones already kept
      while (pos < kept_count && kept_list[pos].x <= it.sprite_x) pos++;
      for (int k = int'(kept_count); k > pos; k--) kept_list[k] = kept_list[k-1];
      kept_list[pos] = {it.sprite_y, it.sprite_x, it.sprite_tile, it.sprite_attrs};
      kept_count++;
    end
    if (!it.last_entry) return;
    scans_seen++;
    if (kept_count == 0) begin
      line_results.insert(line_results.size(),
                          mk_result(4'd0, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0, 1'b1, 1'b1));
      empty_runs++;
      return;
    end
    if (kept_count == MAX_KEPT) full_runs++;
    cnt = (kept_count > 15) ? COUNT_SAT : kept_count[3:0];
    for (int k = 0; k < int'(kept_count); k++) begin
      line_results.insert(line_results.size(),
                          mk_result(k[3:0], kept_list[k].y, kept_list[k].x,
                                    kept_list[k].tile, kept_list[k].attrs, cnt, 1'b0,
                                    k == int'(kept_count) - 1));
    end
  endfunction

  // Random entry, biased into and around the selection window
  function automatic sprite_in_t rand_entry();
    int unsigned target;
    int unsigned height;
    int unsigned y;
    int unsigned r;
    sprite_in_t  e;
    target = line_reg + LINE_OFFSET;
    height = tall_reg ? TALL_HEIGHT : SHORT_HEIGHT;
    r = $urandom_range(0, 99);
    if (r < 60) y = target - $urandom_range(0, height - 1);
    else if (r < 75) y = $urandom_range(0, 1) ? target + 1 : target - height;
    else y = $urandom_range(0, 255);
    if (y > 255) y = $urandom_range(0, 255);
    e = '0;
    e.sprite_y     = y[7:0];
    e.sprite_tile  = 8'($urandom);
    e.sprite_attrs = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 8) e.sprite_x = 8'd0;
    else if (r < 23) e.sprite_x = prev_x;
    else e.sprite_x = 8'($urandom);
    prev_x = e.sprite_x;
    return e;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (fail_count < MAX_REPORTS)
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic check_result(input sprite_out_t got, input sprite_out_t want);
    if (got.slot !== want.slot) report_mismatch("slot", got.slot, want.slot);
    if (got.out_y !== want.out_y) report_mismatch("out_y", got.out_y, want.out_y);
    if (got.out_x !== want.out_x) report_mismatch("out_x", got.out_x, want.out_x);
    if (got.out_tile !== want.out_tile) report_mismatch("out_tile", got.out_tile, want.out_tile);
    if (got.out_attrs !== want.out_attrs)
      report_mismatch("out_attrs", got.out_attrs, want.out_attrs);
    if (got.selected_count !== want.selected_count)
      report_mismatch("selected_count", got.selected_count, want.selected_count);
    if (got.none_found !== want.none_found)
      report_mismatch("none_found", got.none_found, want.none_found);
    if (got.run_last !== want.run_last)
      report_mismatch("run_last", got.run_last, want.run_last);
  endtask

  // Register writes happen only with the block drained and settled
  task automatic write_config(input logic [7:0] line, input logic tall);
    logic [7:0] tall_data;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    tall_data    = 8'($urandom);
    tall_data[0] = tall;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_CURRENT_LINE;
    cfg_data_i <= line;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_TALL_SPRITES;
    cfg_data_i <= tall_data;
    @(negedge clk_i);
    cfg_idx_i  <= $urandom_range(0, 1) ? CFG_IDX_FREE_A : CFG_IDX_FREE_B;
    cfg_data_i <= 8'($urandom);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    line_reg = line;
    tall_reg = tall;
    cfg_updates++;
  endtask

  // Offer one transaction after a random gap; returns at the accepting edge
  task automatic send_entry(input sprite_in_t e, input bit fixed, input sprite_out_t res);
    int unsigned  gap;
    int unsigned  r;
    hand_result_t h;
    r = $urandom_range(0, 99);
    if (tx_calm || r < 70) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else if (r < 98) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 40);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    h.fixed = fixed;
    h.res   = res;
    hand_results_q.insert(hand_results_q.size(), h);
    in_valid_i <= 1'b1;
    in_data_i  <= e;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Predict on input transactions, check output transactions
  always @(posedge clk_i) begin : watch_ports
    hand_result_t h;
    sprite_out_t  want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        h.fixed = 1'b0;
        if (hand_results_q.size() != 0) begin
          h = hand_results_q[0];
          hand_results_q.delete(0);
        end
        select_and_sort(in_data_i);
        entries_seen++;
        if (h.fixed) results_due.insert(results_due.size(), h.res);
        else foreach (line_results[i]) results_due.insert(results_due.size(), line_results[i]);
      end
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing pending, out_x", out_data_o.out_x, 8'h00);
        end else begin
          want = results_due[0];
          results_due.delete(0);
          check_result(out_data_o, want);
        end
      end
    end
  end

  // Receiver pacing, with one long hold-off to back the block up
  initial begin : rx_pacing
    int unsigned stall;
    int unsigned r;
    out_ready_i = 1'b0;
    rx_calm     = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 49) == 0) rx_calm = ~rx_calm;
      if (hold_armed && out_valid_o) begin
        hold_armed = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
        hold_busy = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (rx_calm || r < 65) stall = 0;
        else if (r < 90) stall = $urandom_range(1, 3);
        else if (r < 98) stall = $urandom_range(4, 10);
        else stall = $urandom_range(20, 40);
        if (stall == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          repeat (stall - 1) @(negedge clk_i);
        end
      end
    end
  end

  initial begin : stimulus
    scan_row_t   rows [$];
    scan_row_t   row;
    sprite_in_t  e;
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    logic [7:0]  line;
    logic        tall;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_CURRENT_LINE;
    cfg_data_i   = '0;
    line_reg     = 8'd0;
    tall_reg     = 1'b0;
    kept_count   = '0;
    prev_x       = 8'd1;
    tx_calm      = 1'b0;
    hold_armed   = 1'b0;
    hold_busy    = 1'b0;
    fail_count   = 0;
    entries_seen = 0;
    results_seen = 0;
    scans_seen   = 0;
    empty_runs   = 0;
    full_runs    = 0;
    cfg_updates  = 0;

    // Reset values in effect: one entry inside the window
    row = mk_row(0, 8'd0, 1'b0, mk_entry(1, 1, 8'd16, 8'd8, 8'h3C, 8'hC3));
    row.fixed     = 1'b1;
    row.fixed_res = mk_result(4'd0, 8'd16, 8'd8, 8'h3C, 8'hC3, 4'd1, 1'b0, 1'b1);
    rows.insert(rows.size(), row);
    // Hidden entry only: empty run
    row = mk_row(1, 8'd0, 1'b0, mk_entry(1, 1, 8'd16, 8'd0, 8'hFF, 8'hFF));
    row.fixed     = 1'b1;
    row.fixed_res = mk_result(4'd0, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0, 1'b1, 1'b1);
    rows.insert(rows.size(), row);
    // Tie on x, both window edges, then emit; then emit again with no first
    rows.insert(rows.size(),
                mk_row(0, 8'd0, 1'b0, mk_entry(1, 0, 8'd16, 8'd8, 8'hFF, 8'h00)));
    rows.insert(rows.size(),
                mk_row(0, 8'd0, 1'b0, mk_entry(0, 0, 8'd9, 8'd8, 8'h01, 8'h80)));
    rows.insert(rows.size(),
                mk_row(0, 8'd0, 1'b0, mk_entry(0, 0, 8'd8, 8'd1, 8'h11, 8'h22)));
    rows.insert(rows.size(),
                mk_row(0, 8'd0, 1'b0, mk_entry(0, 0, 8'd17, 8'd255, 8'h33, 8'h44)));
    rows.insert(rows.size(),
                mk_row(0, 8'd0, 1'b0, mk_entry(0, 1, 8'd16, 8'd255, 8'hA5, 8'h5A)));
    rows.insert(rows.size(),
                mk_row(0, 8'd0, 1'b0, mk_entry(0, 1, 8'd0, 8'd0, 8'h00, 8'h00)));
    // First clears the list; entry below the window
    row = mk_row(0, 8'd0, 1'b0, mk_entry(1, 1, 8'd0, 8'd1, 8'h00, 8'h00));
    row.fixed     = 1'b1;
    row.fixed_res = mk_result(4'd0, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0, 1'b1, 1'b1);
    rows.insert(rows.size(), row);
    // Eleven hits in falling x: the list fills and the smallest x is dropped
    for (int k = 0; k < 11; k++) begin
      rows.insert(rows.size(),
                  mk_row(0, 8'd0, 1'b0,
                         mk_entry(k == 0, k == 10, 8'd16,
                                  (k == 10) ? 8'd1 : 8'(200 - 18 * k),
                                  8'(k), 8'(~k))));
    end
    // Last line, tall objects: nothing can reach the window
    row = mk_row(1, 8'd255, 1'b1, mk_entry(1, 1, 8'd255, 8'd255, 8'hFF, 8'hFF));
    row.fixed     = 1'b1;
    row.fixed_res = mk_result(4'd0, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0, 1'b1, 1'b1);
    rows.insert(rows.size(), row);
    // Window at the top of the y range
    rows.insert(rows.size(),
                mk_row(1, 8'd239, 1'b0, mk_entry(1, 0, 8'd255, 8'd255, 8'h5A, 8'hA5)));
    rows.insert(rows.size(),
                mk_row(0, 8'd0, 1'b0, mk_entry(0, 1, 8'd248, 8'd1, 8'h77, 8'h88)));
    // Tall objects on line zero
    rows.insert(rows.size(),
                mk_row(1, 8'd0, 1'b1, mk_entry(1, 0, 8'd0, 8'd1, 8'h12, 8'h34)));
    rows.insert(rows.size(),
                mk_row(0, 8'd0, 1'b0, mk_entry(0, 1, 8'd1, 8'd254, 8'h56, 8'h78)));

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table
    foreach (rows[i]) begin
      if (rows[i].set_cfg) write_config(rows[i].line, rows[i].tall);
      send_entry(rows[i].entry, rows[i].fixed, rows[i].fixed_res);
    end

    // Random line scans
    hold_busy  = 1'b1;
    hold_armed = 1'b1;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      if (!hold_busy && $urandom_range(0, 99) < 40) begin
        r = $urandom_range(0, 99);
        if (r < 15) line = 8'd0;
        else if (r < 30) line = 8'd255;
        else if (r < 40) line = 8'd239;
        else line = 8'($urandom);
        tall = 1'($urandom);
        write_config(line, tall);
      end
      len = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 3) : $urandom_range(5, 40);
      if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
      for (int k = 0; k < int'(len); k++) begin
        e = rand_entry();
        // mostly clean scans, with a few stray first/last marks
        e.first_entry = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
        e.last_entry  = (k == int'(len) - 1) ? 1'b1 : ($urandom_range(0, 49) == 0);
        send_entry(e, 1'b0, '0);
        sent++;
      end
    end

    // Drain and settle
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES * 4) @(posedge clk_i);
    if (results_due.size() != 0)
      report_mismatch("results never delivered, count", 8'(results_due.size()), 8'h00);

    $display("Covered %0d entries over %0d line scans with %0d register updates.",
             entries_seen, scans_seen, cfg_updates);
    $display("Checked %0d results: %0d empty lines, %0d full lists.",
             results_seen, empty_runs, full_runs);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin : watchdog
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
